[hdl/text_console_cursor_engine_top_assert.svh]
// Assertion macros shared by the cursor engine modules
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_TOP_ASSERT_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TCCE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define TCCE_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define TCCE_ASSERT(lbl, clk, rst_n, prop, msg)
`define TCCE_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif
`endif

[hdl/tcce_pkg.sv]
// Shared constants, codes and types of the text console cursor engine
package tcce_pkg;

	localparam int COLUMNS_DEF  = 80;
	localparam int ROWS_DEF     = 25;
	localparam int TAB_STOP_DEF = 8;

	localparam int KIND_W      = 2;
	localparam int CHAR_W      = 8;
	localparam int INDEX_W     = 11;
	localparam int ATTR_W      = 8;
	localparam int CELL_W      = 16;
	localparam int OCOL_W      = 7;
	localparam int OROW_W      = 5;
	localparam int OLIN_W      = 11;
	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 40;

	localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

	localparam logic [CHAR_W-1:0] CHAR_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CHAR_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CHAR_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CHAR_BLANK = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_MAX   = 8'hFF;

	localparam logic [ATTR_W-1:0] ATTR_RESET  = 8'h0F;
	localparam logic [CELL_W-1:0] RESET_BLANK = {ATTR_RESET, CHAR_BLANK};

	typedef enum logic [1:0] {
		SW_INIT,
		SW_CLEAR,
		SW_SCROLL
	} sweep_mode_t;

	typedef struct packed {
		logic        load_item;
		logic        exec_put;
		logic        home;
		logic        sweep_run;
		sweep_mode_t sweep_mode;
		logic        load_out;
	} cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              scroll;
		logic              sweep_last;
	} status_t;

endpackage

[hdl/tcce_ram.sv]
// Simple dual-port RAM with registered read
module tcce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hdl/tcce_ctrl.sv]
// Controller state machine of the cursor engine
`include "text_console_cursor_engine_top_assert.svh"
module tcce_ctrl import tcce_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    s_tvalid,
	output logic    s_tready,
	output logic    m_tvalid,
	input  logic    m_tready,
	output cmd_t    cmd,
	input  status_t status
);

	typedef enum logic [5:0] {
		ST_INIT   = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_EXEC   = 6'b000100,
		ST_CLEAR  = 6'b001000,
		ST_SCROLL = 6'b010000,
		ST_RESP   = 6'b100000
	} state_t;

	state_t state_q, state_d;
	logic   m_tvalid_q;
	logic   slot_free;
	logic   accept;

	assign slot_free = !m_tvalid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE) || ((state_q == ST_RESP) && slot_free);
	assign accept    = s_tvalid && s_tready;
	assign m_tvalid  = m_tvalid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			ST_INIT: begin
				cmd.sweep_run  = 1'b1;
				cmd.sweep_mode = SW_INIT;
				if (status.sweep_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					cmd.load_item = 1'b1;
					state_d       = ST_EXEC;
				end
			end
			ST_EXEC: begin
				case (status.kind)
					KIND_PUT: begin
						cmd.exec_put = 1'b1;
						state_d      = status.scroll ? ST_SCROLL : ST_RESP;
					end
					KIND_CLEAR: begin
						cmd.home = 1'b1;
						state_d  = ST_CLEAR;
					end
					default: state_d = ST_RESP;
				endcase
			end
			ST_CLEAR: begin
				cmd.sweep_run  = 1'b1;
				cmd.sweep_mode = SW_CLEAR;
				if (status.sweep_last) begin
					state_d = ST_RESP;
				end
			end
			ST_SCROLL: begin
				cmd.sweep_run  = 1'b1;
				cmd.sweep_mode = SW_SCROLL;
				if (status.sweep_last) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (slot_free) begin
					cmd.load_out  = 1'b1;
					cmd.load_item = accept;
					state_d       = accept ? ST_EXEC : ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_INIT;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	`TCCE_ASSERT(a_ready_only_idle_resp, clk, arst_n, s_tready |-> (state_q == ST_IDLE || state_q == ST_RESP), "input ready outside idle or response")
	`TCCE_ASSERT(a_accept_to_exec, clk, arst_n, (s_tvalid && s_tready) |=> (state_q == ST_EXEC), "accepted transaction not executed")
	`TCCE_ASSERT(a_resp_loads_free_slot, clk, arst_n, (state_q == ST_RESP && !m_tvalid_q) |=> m_tvalid_q, "result not loaded into free output slot")

endmodule

[hdl/tcce_dp.sv]
// Datapath of the cursor engine: cursor, screen store, sweeps and result register
`include "text_console_cursor_engine_top_assert.svh"
module tcce_dp import tcce_pkg::*; #(
	parameter int COLUMNS  = COLUMNS_DEF,
	parameter int ROWS     = ROWS_DEF,
	parameter int TAB_STOP = TAB_STOP_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  cmd_t                   cmd,
	output status_t                status,
	input  logic [KIND_W-1:0]      item_kind,
	input  logic [CHAR_W-1:0]      item_char,
	input  logic [INDEX_W-1:0]     item_index,
	input  logic                   cfg_valid,
	input  logic [ATTR_W-1:0]      cfg_data,
	output logic [OUT_TDATA_W-1:0] out_tdata
);

	localparam int CELLS    = COLUMNS * ROWS;
	localparam int COL_W    = $clog2(COLUMNS);
	localparam int ROW_W    = $clog2(ROWS);
	localparam int ROWN_W   = ROW_W + 1;
	localparam int ADDR_W   = $clog2(CELLS);
	localparam int TAB_W    = $clog2(TAB_STOP);
	localparam int NCOL_W   = $clog2(COLUMNS + TAB_STOP + 1);
	localparam int IDXW_W   = ADDR_W + INDEX_W;

	logic [ATTR_W-1:0]      attr_q;
	logic [COL_W-1:0]       col_q;
	logic [ROW_W-1:0]       row_q;
	logic [TAB_W-1:0]       tab_q;
	logic [KIND_W-1:0]      kind_q;
	logic [CHAR_W-1:0]      char_q;
	logic [ADDR_W-1:0]      addr_q;
	logic                   in_range_q;
	logic [ADDR_W-1:0]      cnt_q;
	logic                   sw_valid_s1;
	logic [ADDR_W-1:0]      sw_addr_s1;
	logic                   sw_copy_s1;
	logic [CELL_W-1:0]      sw_fill_s1;
	logic [OUT_TDATA_W-1:0] out_tdata_q;

	logic [IDXW_W-1:0] idx_wide;
	logic [NCOL_W-1:0] col_w, ncol;
	logic [TAB_W-1:0]  ntab;
	logic              row_inc, wr_cell;
	logic [ROWN_W-1:0] nrow;
	logic              scroll;
	logic [ADDR_W-1:0] lin;
	logic              sweep_last;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	logic [CELL_W-1:0] ram_wdata, ram_rdata;
	logic [CELL_W-1:0] read_data;

	assign idx_wide = IDXW_W'(item_index);
	assign col_w    = NCOL_W'(col_q);

	always_comb begin
		ncol    = col_w;
		ntab    = tab_q;
		row_inc = 1'b0;
		wr_cell = 1'b0;
		case (char_q) inside
			CHAR_BS: begin
				if (col_q != '0) begin
					ncol = col_w - 1'b1;
					ntab = (tab_q == '0) ? TAB_W'(TAB_STOP - 1) : tab_q - 1'b1;
				end
			end
			CHAR_TAB: begin
				ncol = col_w + NCOL_W'(TAB_STOP) - NCOL_W'(tab_q);
				ntab = '0;
			end
			CHAR_CR: begin
				ncol = '0;
				ntab = '0;
			end
			CHAR_LF: begin
				ncol    = '0;
				ntab    = '0;
				row_inc = 1'b1;
			end
			[CHAR_BLANK:CHAR_MAX]: begin
				ncol    = col_w + 1'b1;
				ntab    = (tab_q == TAB_W'(TAB_STOP - 1)) ? '0 : tab_q + 1'b1;
				wr_cell = 1'b1;
			end
			default: ;
		endcase
		if (ncol >= NCOL_W'(COLUMNS)) begin
			ncol    = '0;
			ntab    = '0;
			row_inc = 1'b1;
		end
	end

	assign nrow       = ROWN_W'(row_q) + ROWN_W'(row_inc);
	assign scroll     = (nrow == ROWN_W'(ROWS));
	assign lin        = ADDR_W'(row_q * COLUMNS + col_q);
	assign sweep_last = (cnt_q == ADDR_W'(CELLS - 1));

	assign status.kind       = kind_q;
	assign status.scroll     = scroll;
	assign status.sweep_last = sweep_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q      <= ATTR_RESET;
			col_q       <= '0;
			row_q       <= '0;
			tab_q       <= '0;
			kind_q      <= KIND_PUT;
			cnt_q       <= '0;
			sw_valid_s1 <= 1'b0;
		end else begin
			if (cfg_valid) begin
				attr_q <= cfg_data;
			end
			if (cmd.load_item) begin
				kind_q <= item_kind;
			end
			if (cmd.home) begin
				col_q <= '0;
				row_q <= '0;
				tab_q <= '0;
			end else if (cmd.exec_put) begin
				col_q <= COL_W'(ncol);
				tab_q <= ntab;
				row_q <= scroll ? ROW_W'(ROWS - 1) : ROW_W'(nrow);
			end
			if (cmd.sweep_run) begin
				cnt_q <= sweep_last ? '0 : cnt_q + 1'b1;
			end
			sw_valid_s1 <= cmd.sweep_run;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			char_q     <= item_char;
			addr_q     <= idx_wide[ADDR_W-1:0];
			in_range_q <= (idx_wide < IDXW_W'(CELLS));
		end
		sw_addr_s1 <= cnt_q;
		sw_copy_s1 <= (cmd.sweep_mode == SW_SCROLL) && (cnt_q < ADDR_W'(CELLS - COLUMNS));
		sw_fill_s1 <= (cmd.sweep_mode == SW_INIT) ? RESET_BLANK : {attr_q, CHAR_BLANK};
		if (cmd.load_out) begin
			out_tdata_q <= {1'b0, read_data, OLIN_W'(lin), OROW_W'(row_q), OCOL_W'(col_q)};
		end
	end

	assign ram_we    = sw_valid_s1 || (cmd.exec_put && wr_cell);
	assign ram_waddr = sw_valid_s1 ? sw_addr_s1 : lin;
	assign ram_wdata = sw_valid_s1 ? (sw_copy_s1 ? ram_rdata : sw_fill_s1) : {attr_q, char_q};
	assign ram_raddr = (cmd.sweep_run && cmd.sweep_mode == SW_SCROLL) ?
		ADDR_W'(cnt_q + COLUMNS) : addr_q;
	assign read_data = (kind_q == KIND_READ && in_range_q) ? ram_rdata : '0;
	assign out_tdata = out_tdata_q;

	tcce_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELLS)
	) u_screen (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	`TCCE_ASSERT(a_cursor_in_screen, clk, arst_n, (32'(col_q) < COLUMNS) && (32'(row_q) < ROWS), "cursor outside screen")
	`TCCE_ASSERT_NEVER(a_single_writer, clk, arst_n, sw_valid_s1 && cmd.exec_put, "sweep write collides with character write")

endmodule

[hdl/text_console_cursor_engine_top.sv]
// Top level of the text console cursor engine
// Put, read and ignored items go from the execute state to the response state, which loads the result
// once the output register is free. Clear and a put that scrolls sweep every cell, one per cycle.
// The next item is accepted while a result waits in the output register.
// Reset: cursor homes, attribute 0x0F; screen store is blanked by a sweep over every cell,
// during which no item is accepted (configuration writes are taken).
module text_console_cursor_engine_top import tcce_pkg::*; #(
	parameter int COLUMNS  = COLUMNS_DEF,
	parameter int ROWS     = ROWS_DEF,
	parameter int TAB_STOP = TAB_STOP_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // char_code, cell_index, zero pad
	input  logic [KIND_W-1:0]      s_tuser,  // kind
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // cursor_column, cursor_row, cursor_linear, read_data, zero pad
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [ATTR_W-1:0]      cfg_data
);

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	tcce_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cmd     (cmd),
		.status  (status)
	);

	tcce_dp #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS),
		.TAB_STOP(TAB_STOP)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.item_kind (s_tuser),
		.item_char (s_tdata[CHAR_W-1:0]),
		.item_index(s_tdata[CHAR_W+INDEX_W-1:CHAR_W]),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.out_tdata (m_tdata)
	);

endmodule
